>>> rtl/hmp_pkg.sv
// hmp_pkg: sizes, codes and types shared by the hash map RTL.
// No dependencies; used by the top level, the bucket update logic and the checker.
package hmp_pkg;

    // table geometry
    localparam int BUCKETS  = 1024;
    localparam int WAYS     = 4;
    localparam int KEY_BITS = 20;

    // port field widths
    localparam int CMD_W    = 2;
    localparam int KEY_IN_W = 20;
    localparam int VAL_W    = 20;
    localparam int STAT_W   = 2;

    // stored key width: the key is used masked to KEY_BITS
    localparam int KEY_W  = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W = 1 + KEY_W + VAL_W;
    localparam int ROW_W  = WAYS * SLOT_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // one slot of a bucket
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    // one memory row: all ways of one bucket
    typedef slot_t [WAYS-1:0] row_t;

    // outcome of one command applied to its bucket
    typedef struct packed {
        logic              wr_en;
        row_t              row;
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  read_value;
    } upd_t;

endpackage

>>> rtl/hash_map_put_get_remove.sv
// hash_map_put_get_remove: top level with the bucket memory, sequencer and
// result register. Depends on hmp_pkg and hmp_bucket_update.
//
//  channel | ports                               | direction | handshake
//  --------+-------------------------------------+-----------+----------------
//  input   | s_command, s_key, s_value           | in        | s_valid/s_ready
//  result  | m_status, m_read_value              | out       | m_valid/m_ready
//
// The single bucket memory has a registered read: the bucket row is read in the
// accept cycle, then compared, updated and written back in the lookup state once
// the result register is free. One result per transaction.
// After reset a clearing pass writes empty rows to all BUCKETS (1024) buckets
// with s_ready low. A stalled result holds in the output register; the next
// transaction is accepted meanwhile and waits in lookup until the register frees.
module hash_map_put_get_remove (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hmp_pkg::CMD_W-1:0]     s_command,
    input  logic [hmp_pkg::KEY_IN_W-1:0]  s_key,
    input  logic [hmp_pkg::VAL_W-1:0]     s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hmp_pkg::STAT_W-1:0]    m_status,
    output logic [hmp_pkg::VAL_W-1:0]     m_read_value
);

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_LOOKUP = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [hmp_pkg::BKT_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [hmp_pkg::CMD_W-1:0]  cmd_reg;
    logic [hmp_pkg::KEY_W-1:0]  key_reg;
    logic [hmp_pkg::VAL_W-1:0]  val_reg;
    logic [hmp_pkg::BKT_W-1:0]  bkt_reg;

    logic                       m_valid_reg, m_valid_next;
    logic [hmp_pkg::STAT_W-1:0] m_status_reg;
    logic [hmp_pkg::VAL_W-1:0]  m_read_value_reg;

    logic [hmp_pkg::ROW_W-1:0]  mem [hmp_pkg::BUCKETS];
    logic [hmp_pkg::ROW_W-1:0]  rd_data_reg;

    logic                       s_acc;
    logic [hmp_pkg::KEY_W-1:0]  s_key_m;
    logic [hmp_pkg::BKT_W-1:0]  s_bkt;
    logic                       out_free;
    logic                       finish;
    logic                       wr_en;
    logic [hmp_pkg::BKT_W-1:0]  wr_addr;
    logic [hmp_pkg::ROW_W-1:0]  wr_data;
    hmp_pkg::upd_t              upd;

    // handshake and key/bucket decode
    assign s_ready  = (state_reg == S_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign s_key_m  = s_key[hmp_pkg::KEY_W-1:0];
    assign s_bkt    = hmp_pkg::BKT_W'(32'(s_key_m) % hmp_pkg::BUCKETS);
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == S_LOOKUP) && out_free;

    // compare and update of the fetched bucket
    hmp_bucket_update u_update (
        .row     (hmp_pkg::row_t'(rd_data_reg)),
        .command (cmd_reg),
        .key     (key_reg),
        .value   (val_reg),
        .upd     (upd)
    );

    // memory write port: clearing pass or write-back
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = bkt_reg;
        wr_data = hmp_pkg::ROW_W'(upd.row);
        if (state_reg == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = '0;
        end else if (finish && upd.wr_en) begin
            wr_en = 1'b1;
        end
    end

    // bucket memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (s_acc) begin
            rd_data_reg <= mem[s_bkt];
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            S_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (32'(clr_idx_reg) == hmp_pkg::BUCKETS - 1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // result valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // transaction and result payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            cmd_reg <= s_command;
            key_reg <= s_key_m;
            val_reg <= s_value;
            bkt_reg <= s_bkt;
        end
        if (finish) begin
            m_status_reg     <= upd.status;
            m_read_value_reg <= upd.read_value;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_read_value = m_read_value_reg;

endmodule

>>> rtl/hmp_bucket_update.sv
// hmp_bucket_update: compares all ways of one bucket against the key and
// builds the written-back row, the status and the read value. Uses hmp_pkg.
module hmp_bucket_update (
    input  hmp_pkg::row_t                   row,
    input  logic [hmp_pkg::CMD_W-1:0]       command,
    input  logic [hmp_pkg::KEY_W-1:0]       key,
    input  logic [hmp_pkg::VAL_W-1:0]       value,
    output hmp_pkg::upd_t                   upd
);

    logic [hmp_pkg::WAYS-1:0] hit_vec;
    logic [hmp_pkg::WAYS-1:0] free_vec;
    logic [hmp_pkg::WAYS-1:0] hit_sel;
    logic [hmp_pkg::WAYS-1:0] free_sel;
    logic                     any_hit;
    logic                     any_free;
    logic [hmp_pkg::VAL_W-1:0] hit_value;

    // per-way match and free flags
    always_comb begin
        for (int w = 0; w < hmp_pkg::WAYS; w++) begin
            hit_vec[w]  = row[w].valid && (row[w].key == key);
            free_vec[w] = !row[w].valid;
        end
    end

    // lowest matching way and lowest free way, one-hot
    always_comb begin
        hit_sel  = '0;
        free_sel = '0;
        for (int w = hmp_pkg::WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_sel = '0;
                hit_sel[w] = 1'b1;
            end
            if (free_vec[w]) begin
                free_sel = '0;
                free_sel[w] = 1'b1;
            end
        end
        any_hit  = |hit_vec;
        any_free = |free_vec;
    end

    // value of the matching slot (zero when none)
    always_comb begin
        hit_value = '0;
        for (int w = 0; w < hmp_pkg::WAYS; w++) begin
            if (hit_sel[w]) begin
                hit_value = hit_value | row[w].value;
            end
        end
    end

    // apply the command
    always_comb begin
        upd            = '0;
        upd.row        = row;
        upd.status     = hmp_pkg::ST_ABSENT;
        upd.read_value = '0;
        unique case (command)
            hmp_pkg::CMD_PUT: begin
                if (any_hit) begin
                    for (int w = 0; w < hmp_pkg::WAYS; w++) begin
                        if (hit_sel[w]) begin
                            upd.row[w].value = value;
                        end
                    end
                    upd.wr_en  = 1'b1;
                    upd.status = hmp_pkg::ST_OK;
                end else if (any_free) begin
                    for (int w = 0; w < hmp_pkg::WAYS; w++) begin
                        if (free_sel[w]) begin
                            upd.row[w].valid = 1'b1;
                            upd.row[w].key   = key;
                            upd.row[w].value = value;
                        end
                    end
                    upd.wr_en  = 1'b1;
                    upd.status = hmp_pkg::ST_OK;
                end else begin
                    upd.status = hmp_pkg::ST_FULL;
                end
            end
            hmp_pkg::CMD_GET: begin
                if (any_hit) begin
                    upd.status     = hmp_pkg::ST_OK;
                    upd.read_value = hit_value;
                end
            end
            hmp_pkg::CMD_REMOVE: begin
                if (any_hit) begin
                    for (int w = 0; w < hmp_pkg::WAYS; w++) begin
                        if (hit_sel[w]) begin
                            upd.row[w].valid = 1'b0;
                        end
                    end
                    upd.wr_en  = 1'b1;
                    upd.status = hmp_pkg::ST_OK;
                end
            end
            default: begin
                // undefined command: no change, key reported absent
                upd.status = hmp_pkg::ST_ABSENT;
            end
        endcase
    end

endmodule

>>> rtl/hmp_checker.sv
// hmp_checker: port-level assertions for hash_map_put_get_remove, bound to
// the top level below. Depends on hmp_pkg.
module hmp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [hmp_pkg::STAT_W-1:0]    m_status,
    input logic [hmp_pkg::VAL_W-1:0]     m_read_value
);

    // one transaction in flight: no accept on the cycle after an accept
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on two consecutive cycles");

    // every accepted transaction is followed by m_valid high (its own or a stalled earlier result)
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##2 m_valid)
        else $error("no result after accepted transaction");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == hmp_pkg::ST_OK || m_status == hmp_pkg::ST_ABSENT ||
                     m_status == hmp_pkg::ST_FULL))
        else $error("undefined status code");

    // read value is zero unless the status is success
    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != hmp_pkg::ST_OK) |-> (m_read_value == '0))
        else $error("nonzero read value with failing status");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_read_value)))
        else $error("result changed while stalled");

endmodule

bind hash_map_put_get_remove hmp_checker u_hmp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_read_value (m_read_value)
);
